// ===== design/tsplat_pkg.sv =====
// ----------------------------------------------------------------------------
// tsplat_pkg
// Shared types and constants for the transport-stream PID arrival latency
// timer: phases, event codes, register indexes and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tsplat_pkg;

   localparam int PID_W = 13;
   localparam int CNT_W = 24;
   localparam int MEAS_W = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [7:0] SYNC_BYTE = 8'h47;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [PID_W-1:0] WATCHED_PID_RST = 13'h0404;
   localparam logic [CNT_W-1:0] TIMEOUT_RST = 24'd20000;
   localparam logic [CNT_W-1:0] REARM_GAP_RST = 24'd1000;
   localparam logic [CNT_W-1:0] INIT_WAIT_RST = 24'd10000;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_OPEN = 2'd1,
      PH_GAP  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_HIT     = 2'd1,
      EV_TIMEOUT = 2'd2
   } event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WATCHED_PID  = 2'd0,
      CSR_TIMEOUT      = 2'd1,
      CSR_REARM_GAP    = 2'd2,
      CSR_INITIAL_WAIT = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef struct packed {
      logic             pid_valid;
      logic [PID_W-1:0] pid;
   } pid_info_type;

   typedef struct packed {
      logic              window_level;
      event_type         event_code;
      logic [CNT_W-1:0]  latency_ticks;
      logic [MEAS_W-1:0] measurement_number;
   } result_type;

endpackage

`default_nettype wire

// ===== design/tsplat_sync_parser.sv =====
// ----------------------------------------------------------------------------
// tsplat_sync_parser
// Sync hunter and packet byte counter; flags the PID at packet byte 2.
// ----------------------------------------------------------------------------
`default_nettype none

module tsplat_sync_parser #(
   parameter int PACKET_BYTES = 188
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       byte_strobe,
   input  wire logic [7:0]                 stream_byte,
   output tsplat_pkg::pid_info_type        pid_info
);
   import tsplat_pkg::*;

   localparam logic [8:0] PKT_LEN = 9'(PACKET_BYTES);

   logic       in_packet_ff, in_packet_in;
   logic [7:0] pos_ff, pos_in;
   logic [4:0] pid_hi_ff, pid_hi_in;
   logic [8:0] pos_sum;

   assign pos_sum = {1'b0, pos_ff} + 9'd1;

   always_comb begin
      in_packet_in = in_packet_ff;
      pos_in       = pos_ff;
      pid_hi_in    = pid_hi_ff;
      if (byte_strobe) begin
         if (!in_packet_ff) begin
            if (stream_byte == SYNC_BYTE) begin
               in_packet_in = 1'b1;
               pos_in       = 8'd1;
            end
         end else begin
            if (pos_ff == 8'd1) begin
               pid_hi_in = stream_byte[4:0];
            end
            if (pos_sum >= PKT_LEN) begin
               in_packet_in = 1'b0;
               pos_in       = 8'd0;
            end else begin
               pos_in = pos_sum[7:0];
            end
         end
      end
   end

   assign pid_info.pid_valid = byte_strobe && in_packet_ff && (pos_ff == 8'd2);
   assign pid_info.pid       = {pid_hi_ff, stream_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff <= 1'b0;
         pos_ff       <= 8'd0;
         pid_hi_ff    <= 5'd0;
      end else begin
         in_packet_ff <= in_packet_in;
         pos_ff       <= pos_in;
         pid_hi_ff    <= pid_hi_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !in_packet_ff |-> pos_ff == 8'd0)
      else $error("position nonzero while hunting sync");

   assert property (@(posedge clock) disable iff (reset)
      in_packet_ff |-> ({1'b0, pos_ff} < PKT_LEN && pos_ff != 8'd0))
      else $error("position out of packet range");

   assert property (@(posedge clock) disable iff (reset)
      (byte_strobe && !in_packet_ff && stream_byte == SYNC_BYTE) |=>
         (in_packet_ff && pos_ff == 8'd1))
      else $error("sync byte did not start a packet");

endmodule

`default_nettype wire

// ===== design/ts_pid_arrival_latency_timer_unit.sv =====
// ----------------------------------------------------------------------------
// ts_pid_arrival_latency_timer_unit
// Measures ticks from window arming to arrival of a watched transport-stream
// PID, with timeout, re-arm gap and initial wait.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   req     | req_valid/stall, opcode, byte      | in
//   rsp     | rsp_valid/stall, level/event/...   | out
//   csr     | csr_write_enable/index/data        | in
//
// One item per cycle while req_stall is low; each item yields one result.
// The result register plus a skid register keep req open while rsp stalls;
// req_stall rises only when both are full.
// Synchronous reset clears timer phase, counters, parser and valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_pid_arrival_latency_timer_unit #(
   parameter int PACKET_BYTES = 188
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_opcode,
   input  wire logic [7:0]                         req_stream_byte,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_window_level,
   output logic [1:0]                              rsp_event_code,
   output logic [tsplat_pkg::CNT_W-1:0]            rsp_latency_ticks,
   output logic [tsplat_pkg::MEAS_W-1:0]           rsp_measurement_number,
   input  wire logic                               csr_write_enable,
   input  wire logic [tsplat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tsplat_pkg::CNT_W-1:0]       csr_write_data
);
   import tsplat_pkg::*;

   logic [PID_W-1:0]  watched_pid_ff;
   logic [CNT_W-1:0]  timeout_ff, gap_ff, init_wait_ff;

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_inc;
   logic [MEAS_W-1:0] meas_ff, meas_in;

   result_type        res;
   result_type        out_ff, out_in, skid_ff, skid_in;
   logic              out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic              accept, take, is_tick, byte_strobe, hit;
   pid_info_type      pid_info;

   assign accept      = req_valid && !req_stall;
   assign take        = out_valid_ff && !rsp_stall;
   assign is_tick     = (req_opcode == OP_TICK);
   assign byte_strobe = accept && !is_tick;
   assign req_stall   = skid_valid_ff;

   tsplat_sync_parser #(
      .PACKET_BYTES(PACKET_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_strobe(byte_strobe),
      .stream_byte(req_stream_byte),
      .pid_info   (pid_info)
   );

   assign hit     = pid_info.pid_valid && (phase_ff == PH_OPEN)
                    && (pid_info.pid == watched_pid_ff);
   assign cnt_inc = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         watched_pid_ff <= WATCHED_PID_RST;
         timeout_ff     <= TIMEOUT_RST;
         gap_ff         <= REARM_GAP_RST;
         init_wait_ff   <= INIT_WAIT_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_WATCHED_PID:  watched_pid_ff <= csr_write_data[PID_W-1:0];
            CSR_TIMEOUT:      timeout_ff     <= csr_write_data;
            CSR_REARM_GAP:    gap_ff         <= csr_write_data;
            CSR_INITIAL_WAIT: init_wait_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_WAIT: if (is_tick && cnt_inc >= init_wait_ff) phase_in = PH_OPEN;
            PH_OPEN: if ((is_tick && cnt_inc >= timeout_ff) || hit) phase_in = PH_GAP;
            PH_GAP:  if (is_tick && cnt_inc >= gap_ff) phase_in = PH_OPEN;
            default: phase_in = phase_ff;
         endcase
      end
   end

   // counters and result
   always_comb begin
      cnt_in  = cnt_ff;
      meas_in = meas_ff;
      res.event_code    = EV_NONE;
      res.latency_ticks = '0;
      if (accept) begin
         if (is_tick) begin
            cnt_in = cnt_inc;
            unique case (phase_ff)
               PH_OPEN: begin
                  if (phase_in == PH_GAP) begin
                     res.event_code = EV_TIMEOUT;
                     cnt_in         = '0;
                  end
               end
               PH_WAIT, PH_GAP: begin
                  if (phase_in == PH_OPEN) begin
                     cnt_in  = '0;
                     meas_in = meas_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end else if (hit) begin
            res.event_code    = EV_HIT;
            res.latency_ticks = cnt_ff;
            cnt_in            = '0;
         end
      end
      res.window_level       = (phase_in == PH_OPEN);
      res.measurement_number = meas_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         cnt_ff   <= '0;
         meas_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         meas_ff  <= meas_in;
      end
   end

   // result register with skid stage
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !take) begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = res;
            out_valid_in = 1'b1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_window_level       = out_ff.window_level;
   assign rsp_event_code         = out_ff.event_code;
   assign rsp_latency_ticks      = out_ff.latency_ticks;
   assign rsp_measurement_number = out_ff.measurement_number;

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while output register is empty");

   assert property (@(posedge clock) disable iff (reset)
      (accept && res.event_code != EV_NONE) |=> (phase_ff == PH_GAP && cnt_ff == '0))
      else $error("window end did not enter gap with cleared count");

   assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff != PH_OPEN && phase_in == PH_OPEN) |=> cnt_ff == '0)
      else $error("arming did not clear tick count");

   assert property (@(posedge clock)
      (!reset && !$past(reset)) |->
         (meas_ff == $past(meas_ff) || meas_ff == $past(meas_ff) + 1'b1))
      else $error("measurement count moved by more than one");

endmodule

`default_nettype wire
